// ----- src/rmq_pkg.sv -----
// Shared widths and sideband types for the rotation-matrix-to-quaternion pipeline.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package rmq_pkg;

  // Fixed-point format of matrix elements and quaternion components.
  localparam int FRAC_BITS = 14;
  localparam int IW        = 16;

  // Signed width of the component vector (pair sums and the root argument).
  localparam int VW  = ((FRAC_BITS > IW) ? FRAC_BITS : IW) + 3;
  // Magnitude width of one component.
  localparam int MW  = VW - 1;
  // Sum of four squares, and the root of it.
  localparam int SW  = 2 * MW + 2;
  localparam int RW  = SW / 2;
  // Quotient width; the quotient never exceeds 1.0 plus a rounding step.
  localparam int QW  = FRAC_BITS + 2;
  // Rounded numerator: mag * 2^(FRAC_BITS+1) + length.
  localparam int NW  = MW + FRAC_BITS + 2;
  // Working width of the divider remainder and shifted divisor.
  localparam int AW  = ((NW > RW + QW) ? NW : RW + QW) + 1;
  // Width used for the final saturation compare.
  localparam int OW  = ((QW > IW) ? QW : IW) + 1;

  // Cycles from an accepted start to the result strobe.
  localparam int LATENCY = RW + QW + 6;

  // Sideband that travels beside the square root.
  typedef struct packed {
    logic                  bad;
    logic [3:0]            neg;
    logic [3:0][MW-1:0]    mag;
  } root_side_t;

  // Sideband that travels beside the divider.
  typedef struct packed {
    logic       bad;
    logic [3:0] neg;
  } div_side_t;

endpackage

// ----- src/rmq_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a sideband.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_sqrt
  import rmq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [SW-1:0]     rad_i,
  input  root_side_t        side_i,
  output logic              valid_o,
  output logic [RW-1:0]     root_o,
  output root_side_t        side_o
);

  localparam int RMW = RW + 2;

  logic [RW-1:0]            vld_q;
  logic [RW-1:0][SW-1:0]    rad_q;
  logic [RW-1:0][RMW-1:0]   rem_q;
  logic [RW-1:0][RW-1:0]    root_q;
  root_side_t [RW-1:0]      side_q;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic             vld_in;
    logic [SW-1:0]    rad_in;
    logic [RMW-1:0]   rem_in;
    logic [RW-1:0]    root_in;
    root_side_t       side_in;
    logic [RMW-1:0]   rem_sh;
    logic [RMW-1:0]   trial;
    logic             take;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign rem_sh = {rem_in[RW-1:0], rad_in[SW-1:SW-2]};
    assign trial  = {root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= {rad_in[SW-3:0], 2'b00};
      rem_q[k]  <= take ? (rem_sh - trial) : rem_sh;
      root_q[k] <= {root_in[RW-2:0], take};
      side_q[k] <= side_in;
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

// ----- src/rmq_div.sv -----
// Four-lane pipelined restoring divider, one quotient bit per stage, with a sideband.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_div
  import rmq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [3:0][NW-1:0]   num_i,
  input  logic [RW:0]          den_i,
  input  div_side_t            side_i,
  output logic                 valid_o,
  output logic [3:0][QW-1:0]   quo_o,
  output div_side_t            side_o
);

  logic [QW-1:0]                 vld_q;
  logic [QW-1:0][3:0][AW-1:0]    rem_q;
  logic [QW-1:0][3:0][QW-1:0]    quo_q;
  logic [QW-1:0][RW:0]           den_q;
  div_side_t [QW-1:0]            side_q;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic                 vld_in;
    logic [3:0][AW-1:0]   rem_in;
    logic [3:0][QW-1:0]   quo_in;
    logic [RW:0]          den_in;
    div_side_t            side_in;
    logic [AW-1:0]        sub;
    logic [3:0][AW-1:0]   rem_d;
    logic [3:0][QW-1:0]   quo_d;

    if (j == 0) begin : g_first
      for (genvar l = 0; l < 4; l++) begin : g_lane
        assign rem_in[l] = AW'(num_i[l]);
      end
      assign vld_in  = valid_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign den_in  = den_q[j-1];
      assign side_in = side_q[j-1];
    end

    // Divisor aligned to the quotient bit of this stage.
    assign sub = AW'(den_in) << K;

    // Each lane subtracts where the remainder allows it.
    always_comb begin
      for (int l = 0; l < 4; l++) begin
        if (rem_in[l] >= sub) begin
          rem_d[l] = rem_in[l] - sub;
          quo_d[l] = {quo_in[l][QW-2:0], 1'b1};
        end else begin
          rem_d[l] = rem_in[l];
          quo_d[l] = {quo_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j]  <= rem_d;
      quo_q[j]  <= quo_d;
      den_q[j]  <= den_in;
      side_q[j] <= side_in;
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ----- src/rotation_matrix_to_quaternion.sv -----
// Top level: rotation matrix in Q1.14 to unit quaternion, fully pipelined.
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
`timescale 1ns / 1ps

// A matrix is taken on any cycle with start_i high; busy_o is always low, so
// one matrix can enter every cycle. Its quaternion appears on qx_o..qw_o with
// bad_input_o for exactly one cycle, marked by done_o. On its way the matrix
// passes branch selection, magnitude, squaring and summing, the pipelined
// square root of the 19-bit length, a setup register, the pipelined divider
// for the 16-bit quotient, and the output register. The receiver cannot stall;
// results are in the order the matrices entered.
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic signed [IW-1:0] m00_i,
  input  logic signed [IW-1:0] m01_i,
  input  logic signed [IW-1:0] m02_i,
  input  logic signed [IW-1:0] m10_i,
  input  logic signed [IW-1:0] m11_i,
  input  logic signed [IW-1:0] m12_i,
  input  logic signed [IW-1:0] m20_i,
  input  logic signed [IW-1:0] m21_i,
  input  logic signed [IW-1:0] m22_i,
  output logic                 done_o,
  output logic signed [IW-1:0] qx_o,
  output logic signed [IW-1:0] qy_o,
  output logic signed [IW-1:0] qz_o,
  output logic signed [IW-1:0] qw_o,
  output logic                 bad_input_o
);

  localparam logic signed [VW-1:0] ONE = VW'(1) << FRAC_BITS;

  assign busy_o = 1'b0;

  // Branch selection and component vector.
  logic signed [VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [VW-1:0] trace;
  logic signed [VW-1:0] arg;
  logic signed [3:0][VW-1:0] vec_d;

  assign e00 = VW'(m00_i);
  assign e01 = VW'(m01_i);
  assign e02 = VW'(m02_i);
  assign e10 = VW'(m10_i);
  assign e11 = VW'(m11_i);
  assign e12 = VW'(m12_i);
  assign e20 = VW'(m20_i);
  assign e21 = VW'(m21_i);
  assign e22 = VW'(m22_i);
  assign trace = e00 + e11 + e22;

  always_comb begin
    if (trace > 0) begin
      arg      = ONE + trace;
      vec_d[0] = e12 - e21;
      vec_d[1] = e20 - e02;
      vec_d[2] = e01 - e10;
      vec_d[3] = arg;
    end else if ((m00_i > m11_i) && (m00_i > m22_i)) begin
      arg      = ONE + e00 - e11 - e22;
      vec_d[0] = arg;
      vec_d[1] = e10 + e01;
      vec_d[2] = e20 + e02;
      vec_d[3] = e12 - e21;
    end else if (m11_i > m22_i) begin
      arg      = ONE + e11 - e00 - e22;
      vec_d[0] = e10 + e01;
      vec_d[1] = arg;
      vec_d[2] = e21 + e12;
      vec_d[3] = e20 - e02;
    end else begin
      arg      = ONE + e22 - e00 - e11;
      vec_d[0] = e20 + e02;
      vec_d[1] = e12 + e21;
      vec_d[2] = arg;
      vec_d[3] = e01 - e10;
    end
  end

  logic                      vld_a_q, vld_b_q, vld_c_q, vld_d_q;
  logic signed [3:0][VW-1:0] vec_a_q;
  logic                      bad_a_q, bad_b_q, bad_c_q, bad_d_q;
  logic [3:0]                neg_b_q, neg_c_q, neg_d_q;
  logic [3:0][MW-1:0]        mag_b_q, mag_c_q, mag_d_q;
  logic [3:0][2*MW-1:0]      sq_c_q;
  logic [SW-1:0]             sum_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else begin
      vld_a_q <= start_i && !busy_o;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
    end
  end

  // Front stages: select, take magnitudes, square, sum.
  always_ff @(posedge clk_i) begin
    vec_a_q <= vec_d;
    bad_a_q <= !(arg > 0);
    bad_b_q <= bad_a_q;
    for (int l = 0; l < 4; l++) begin
      neg_b_q[l] <= vec_a_q[l][VW-1];
      mag_b_q[l] <= vec_a_q[l][VW-1] ? MW'(-vec_a_q[l]) : MW'(vec_a_q[l]);
      sq_c_q[l]  <= (2*MW)'(mag_b_q[l]) * (2*MW)'(mag_b_q[l]);
    end
    bad_c_q <= bad_b_q;
    neg_c_q <= neg_b_q;
    mag_c_q <= mag_b_q;
    sum_d_q <= SW'(sq_c_q[0]) + SW'(sq_c_q[1]) + SW'(sq_c_q[2]) + SW'(sq_c_q[3]);
    bad_d_q <= bad_c_q;
    neg_d_q <= neg_c_q;
    mag_d_q <= mag_c_q;
  end

  // Length of the vector.
  root_side_t rs_in, rs_out;
  logic       rt_vld;
  logic [RW-1:0] rt_len;

  assign rs_in.bad = bad_d_q;
  assign rs_in.neg = neg_d_q;
  assign rs_in.mag = mag_d_q;

  rmq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_d_q),
    .rad_i   (sum_d_q),
    .side_i  (rs_in),
    .valid_o (rt_vld),
    .root_o  (rt_len),
    .side_o  (rs_out)
  );

  // Divider setup: rounded numerator and doubled length.
  logic                vld_e_q;
  logic [3:0][NW-1:0]  num_e_q;
  logic [RW:0]         den_e_q;
  div_side_t           ds_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_e_q <= 1'b0;
    end else begin
      vld_e_q <= rt_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      num_e_q[l] <= (NW'(rs_out.mag[l]) << (FRAC_BITS + 1)) + NW'(rt_len);
    end
    den_e_q    <= {rt_len, 1'b0};
    ds_e_q.bad <= rs_out.bad || (rt_len == '0);
    ds_e_q.neg <= rs_out.neg;
  end

  logic               dv_vld;
  logic [3:0][QW-1:0] dv_quo;
  div_side_t          ds_out;

  rmq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_e_q),
    .num_i   (num_e_q),
    .den_i   (den_e_q),
    .side_i  (ds_e_q),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .side_o  (ds_out)
  );

  // Sign, saturate and force zero on a bad input.
  localparam logic [OW-1:0] POS_MAX = OW'(32767);
  localparam logic [OW-1:0] NEG_MAX = OW'(32768);

  logic [3:0][IW-1:0] q_d;
  logic [3:0][IW-1:0] q_q;
  logic               bad_q;
  logic               done_q;

  always_comb begin
    logic [OW-1:0] qe;
    logic [OW-1:0] qn;
    for (int l = 0; l < 4; l++) begin
      qe = OW'(dv_quo[l]);
      qn = OW'(0) - qe;
      if (ds_out.bad) begin
        q_d[l] = '0;
      end else if (ds_out.neg[l]) begin
        q_d[l] = (qe > NEG_MAX) ? IW'(16'h8000) : qn[IW-1:0];
      end else begin
        q_d[l] = (qe > POS_MAX) ? IW'(16'h7fff) : qe[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    bad_q <= ds_out.bad;
  end

  assign done_o      = done_q;
  assign qx_o        = q_q[0];
  assign qy_o        = q_q[1];
  assign qz_o        = q_q[2];
  assign qw_o        = q_q[3];
  assign bad_input_o = bad_q;

  // Every accepted matrix yields exactly one strobe after the fixed latency.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("result strobe missing after accepted transfer");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##LATENCY !done_o)
    else $error("result strobe without an accepted transfer");

  // A flagged result carries an all-zero quaternion.
  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bad_input_o) |-> (qx_o == '0 && qy_o == '0 && qz_o == '0 && qw_o == '0))
    else $error("flagged result has nonzero components");

endmodule

// ----- test/rotation_matrix_to_quaternion_test.sv -----
// Self-checking testbench for rotation_matrix_to_quaternion: directed matrices,
// then random rotations and raw matrices, all checked against a local predictor.
// Depends on rmq_pkg and the rotation_matrix_to_quaternion RTL.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;

  typedef logic signed [IW-1:0] matrix_t [9];

  typedef struct packed {
    logic signed [IW-1:0] qx;
    logic signed [IW-1:0] qy;
    logic signed [IW-1:0] qz;
    logic signed [IW-1:0] qw;
    logic                 bad;
  } quat_t;

  typedef struct {
    matrix_t m;
    bit      typed;
    quat_t   q;
  } row_t;

  localparam int ONE         = 1 << FRAC_BITS;
  localparam int RANDOM_ITEMS = 2000;
  localparam int STALL_LIMIT = 1000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic signed [IW-1:0] m00_i, m01_i, m02_i, m10_i, m11_i, m12_i, m20_i, m21_i, m22_i;
  logic                 done_o;
  logic signed [IW-1:0] qx_o, qy_o, qz_o, qw_o;
  logic                 bad_input_o;

  quat_t quat_pending[$];
  row_t  directed_rows[$];
  int    mismatches;
  int    matrices_sent;
  int    quats_seen;
  int    rotations_sent;
  int    idle_cycles;

  rotation_matrix_to_quaternion dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .m00_i, .m01_i, .m02_i, .m10_i, .m11_i, .m12_i, .m20_i, .m21_i, .m22_i,
    .done_o, .qx_o, .qy_o, .qz_o, .qw_o, .bad_input_o
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Shepperd's method on exact integers, then normalization by the floored length.
  function automatic quat_t to_quaternion(matrix_t m);
    longint e[9];
    longint v[4];
    longint arg, tr, s, len, mag, q;
    logic signed [IW-1:0] c[4];
    quat_t r;
    foreach (e[i]) e[i] = m[i];
    tr = e[0] + e[4] + e[8];
    if (tr > 0) begin
      arg = ONE + tr;
      v = '{e[5] - e[7], e[6] - e[2], e[1] - e[3], arg};
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      arg = ONE + e[0] - e[4] - e[8];
      v = '{arg, e[3] + e[1], e[6] + e[2], e[5] - e[7]};
    end else if (e[4] > e[8]) begin
      arg = ONE + e[4] - e[0] - e[8];
      v = '{e[3] + e[1], arg, e[7] + e[5], e[6] - e[2]};
    end else begin
      arg = ONE + e[8] - e[0] - e[4];
      v = '{e[6] + e[2], e[5] + e[7], arg, e[1] - e[3]};
    end
    r = '0;
    if (arg <= 0) begin
      r.bad = 1'b1;
      return r;
    end
    s = 0;
    foreach (v[i]) s += v[i] * v[i];
    // Bitwise integer root, most significant bit first.
    len = 0;
    for (int b = 24; b >= 0; b--) begin
      if ((len + (longint'(1) << b)) * (len + (longint'(1) << b)) <= s)
        len += longint'(1) << b;
    end
    if (len == 0) begin
      r.bad = 1'b1;
      return r;
    end
    foreach (v[i]) begin
      mag = (v[i] < 0) ? -v[i] : v[i];
      q = (mag * ONE * 2 + len) / (len * 2);
      if (v[i] < 0) c[i] = (q > 32768) ? IW'(-32768) : IW'(-q);
      else c[i] = (q > 32767) ? IW'(32767) : IW'(q);
    end
    r.qx = c[0];
    r.qy = c[1];
    r.qz = c[2];
    r.qw = c[3];
    return r;
  endfunction

  // Record each transfer in and check each result against the oldest expectation.
  always @(posedge clk_i) begin
    quat_t want, got;
    if (rst_ni && done_o) begin
      got = '{qx_o, qy_o, qz_o, qw_o, bad_input_o};
      quats_seen++;
      if (quat_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
      end else begin
        want = quat_pending.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
    if (rst_ni && start_i && !busy_o) begin
      quat_pending.push_back(to_quaternion(
        '{m00_i, m01_i, m02_i, m10_i, m11_i, m12_i, m20_i, m21_i, m22_i}));
      matrices_sent++;
    end
  end

  // Watchdog: the run ends if no transfer happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog expired with %0d results pending", quat_pending.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_matrix(matrix_t m);
    {m00_i, m01_i, m02_i, m10_i, m11_i, m12_i, m20_i, m21_i, m22_i} <=
      {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle_gap();
    int n;
    case ($urandom_range(9)) inside
      [0:2]:   n = $urandom_range(1, 3);
      3:       n = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : 0;
      default: n = 0;
    endcase
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [IW-1:0] to_fixed(real x);
    return IW'($rtoi(x * ONE + ((x >= 0.0) ? 0.5 : -0.5)));
  endfunction

  // Proper rotation Rz(a) * Ry(b) * Rx(c) quantized to Q1.14.
  function automatic matrix_t random_rotation();
    real a, b, c, ca, sa, cb, sb, cc, sc;
    matrix_t m;
    a = $urandom_range(0, 62831) / 10000.0;
    b = $urandom_range(0, 62831) / 10000.0;
    c = $urandom_range(0, 62831) / 10000.0;
    ca = $cos(a); sa = $sin(a); cb = $cos(b); sb = $sin(b); cc = $cos(c); sc = $sin(c);
    m[0] = to_fixed(ca * cb);
    m[1] = to_fixed(ca * sb * sc - sa * cc);
    m[2] = to_fixed(ca * sb * cc + sa * sc);
    m[3] = to_fixed(sa * cb);
    m[4] = to_fixed(sa * sb * sc + ca * cc);
    m[5] = to_fixed(sa * sb * cc - ca * sc);
    m[6] = to_fixed(-sb);
    m[7] = to_fixed(cb * sc);
    m[8] = to_fixed(cb * cc);
    return m;
  endfunction

  function automatic void add_row(matrix_t m, bit typed, quat_t q);
    row_t r;
    r.m = m;
    r.typed = typed;
    r.q = q;
    directed_rows.push_back(r);
  endfunction

  initial begin
    matrix_t m;
    quat_t   q;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    {m00_i, m01_i, m02_i, m10_i, m11_i, m12_i, m20_i, m21_i, m22_i} = '0;
    mismatches = 0;
    matrices_sent = 0;
    quats_seen = 0;
    rotations_sent = 0;

    // Directed rows: pure branch cases and all-equal diagonals typed in, extremes and other ties predicted.
    add_row('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1, '{0, 0, 0, ONE, 0});
    add_row('{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 1, '{ONE, 0, 0, 0, 0});
    add_row('{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}, 1, '{0, ONE, 0, 0, 0});
    add_row('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}, 1, '{0, 0, ONE, 0, 0});
    add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, ONE, 0, 0});
    add_row('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 1, '{0, 0, ONE, 0, 0});
    add_row('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 0, '0);
    add_row('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
            0, '0);
    add_row('{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767}, 0, '0);
    add_row('{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768}, 0, '0);
    // Trace exactly zero, trace one, and ties among the diagonal.
    add_row('{ONE, 100, -200, 300, -ONE, 400, -500, 600, 0}, 0, '0);
    add_row('{1, 700, 0, 0, 0, -900, 0, 0, 0}, 0, '0);
    add_row('{-100, 1234, -4321, 2222, -100, 3333, -5555, 6666, -100}, 0, '0);
    add_row('{-50, 9, 8, 7, -50, 6, 5, 4, -900}, 0, '0);
    add_row('{-900, 9, 8, 7, -50, 6, 5, 4, -50}, 0, '0);
    add_row('{-50, 32767, -32768, 32767, -900, -32768, 32767, 32767, -50}, 0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) begin
        q = to_quaternion(directed_rows[i].m);
        if (q !== directed_rows[i].q) begin
          mismatches++;
          $display("Directed row %0d: table %p, predictor %p", i, directed_rows[i].q, q);
        end
      end
      send_matrix(directed_rows[i].m);
      idle_gap();
    end

    // Random part: mostly quantized rotations, some perturbed, some raw noise.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        // Let the last transfer be recorded before waiting for the pipeline to drain.
        start_i <= 1'b0;
        @(posedge clk_i);
        while (quat_pending.size() != 0) @(posedge clk_i);
      end
      case ($urandom_range(9)) inside
        [0:5]: begin
          m = random_rotation();
          rotations_sent++;
        end
        [6:7]: begin
          m = random_rotation();
          foreach (m[k]) m[k] = IW'(m[k] + $signed(IW'($urandom_range(0, 512))) - 256);
        end
        default: foreach (m[k]) m[k] = IW'($urandom());
      endcase
      send_matrix(m);
      idle_gap();
    end
    start_i <= 1'b0;

    while (quat_pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);

    $display("Sent %0d matrices (%0d clean rotations), checked %0d quaternions, %0d mismatches",
             matrices_sent, rotations_sent, quats_seen, mismatches);
    if (mismatches == 0 && quat_pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/rmq_pkg.sv
src/rmq_sqrt.sv
src/rmq_div.sv
src/rotation_matrix_to_quaternion.sv
test/rotation_matrix_to_quaternion_test.sv
